@@ design/heightfield_normal_stencil_macros.svh @@
// Assertion macros of the heightfield normal stencil; the back end uses them.
`ifndef HEIGHTFIELD_NORMAL_STENCIL_MACROS_SVH
`define HEIGHTFIELD_NORMAL_STENCIL_MACROS_SVH

`ifndef SYNTHESIS
// Check a property on every rising clock edge outside reset
`define HNS_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("hns assertion failed");
// Check that a condition never holds
`define HNS_NEVER(label, cond) `HNS_ASSERT(label, !(cond))
`else
`define HNS_ASSERT(label, prop)
`define HNS_NEVER(label, cond)
`endif

`endif

@@ design/hns_pkg.sv @@
// Types and constants of the heightfield normal stencil.
package hns_pkg;

  localparam int HEIGHT_BITS      = 16;
  localparam int NORMAL_FRAC_BITS = 14;
  localparam int HFRAC            = 8;
  localparam int DIFF_W           = HEIGHT_BITS + 1;
  localparam int MAG_W            = DIFF_W + 1;
  localparam int SUM_W            = 2 * MAG_W + 2;
  localparam int ROOT_W           = SUM_W / 2;
  localparam int NUM_W            = MAG_W + NORMAL_FRAC_BITS + 1;
  localparam int REM_W            = ROOT_W + 1;
  localparam int COL_W            = 10;
  localparam int ROW_W            = 16;
  localparam int NXY_W            = 16;
  localparam int NZ_W             = 15;
  localparam int RW_REG_W         = 11;
  localparam int RC_REG_W         = 16;
  localparam int QUEUE_DEPTH      = 4;

  // Register index, taken from paddr bit 2
  localparam logic REG_ROW_WIDTH = 1'b0;
  localparam logic REG_ROW_COUNT = 1'b1;

  typedef logic signed [HEIGHT_BITS-1:0] height_t;

  localparam height_t HEIGHT_MAX = {1'b0, {(HEIGHT_BITS-1){1'b1}}};
  localparam height_t HEIGHT_MIN = {1'b1, {(HEIGHT_BITS-1){1'b0}}};

  typedef struct packed {
    logic [RW_REG_W-1:0] row_width;
    logic [RC_REG_W-1:0] row_count;
  } cfg_t;

  // One normal to compute: differences, spacing and the fields passed along
  typedef struct packed {
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
    logic                     xx2;
    logic                     yy2;
    logic [COL_W-1:0]         col;
    logic [ROW_W-1:0]         row;
    logic                     last;
    logic                     fdone;
    height_t                  hmin;
    height_t                  hmax;
  } job_t;

endpackage

@@ design/hns_stream_if.sv @@
// Stream channels of the heightfield normal stencil: heights in, normals out.
interface hns_in_if;
  import hns_pkg::*;
  logic    valid;
  logic    ready;
  height_t height;
  modport source (output valid, output height, input ready);
  modport sink (input valid, input height, output ready);
endinterface

interface hns_out_if;
  import hns_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [NXY_W-1:0] normal_x;
  logic signed [NXY_W-1:0] normal_y;
  logic [NZ_W-1:0]         normal_z;
  logic [COL_W-1:0]        col;
  logic [ROW_W-1:0]        row_index;
  logic                    last_of_run;
  logic                    frame_done;
  height_t                 height_min;
  height_t                 height_max;
  modport source (output valid, output normal_x, output normal_y, output normal_z,
                  output col, output row_index, output last_of_run, output frame_done,
                  output height_min, output height_max, input ready);
  modport sink (input valid, input normal_x, input normal_y, input normal_z,
                input col, input row_index, input last_of_run, input frame_done,
                input height_min, input height_max, output ready);
endinterface

@@ design/hns_front.sv @@
// Front end: accepts heights, runs the line buffers and builds normal jobs.
module hns_front #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  hns_in_if.sink        in_i,
  input  hns_pkg::cfg_t cfg_i,
  output hns_pkg::job_t job_o,
  output logic          job_valid_o,
  input  logic          job_ready_i
);
  import hns_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = 2 * HEIGHT_BITS;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_CALC = 2'd2;
  localparam logic [1:0] ST_PUSH = 2'd3;

  function automatic logic signed [DIFF_W-1:0] diff(height_t a, height_t b);
    return $signed({a[HEIGHT_BITS-1], a}) - $signed({b[HEIGHT_BITS-1], b});
  endfunction

  logic [1:0]       state_q, state_d;
  logic [CW-1:0]    col_q;
  logic [ROW_W-1:0] row_q;
  height_t          left_q, min_q, max_q;
  height_t          h_q;
  logic [CW-1:0]    c_q;
  logic [ROW_W-1:0] r_q;
  logic             lastcol_q, lastrow_q;
  logic [2:0]       rd_cnt_q;
  logic [WW-1:0]    slot_q [4];
  job_t             jobs_q [3];
  logic [2:0]       jv_q;
  logic [1:0]       push_idx_q;

  // Line buffers: previous row in the low half, the row before in the high half
  logic [WW-1:0]    mem_q [MAX_WIDTH];
  logic [WW-1:0]    rdata_q;
  logic [CW-1:0]    rd_addr;
  logic             mem_we;
  logic [WW-1:0]    wdata;

  logic [CW-1:0]    last_col_w, c_cur;
  logic [ROW_W-1:0] last_row_w, r_cur;
  logic             accept;

  // Clamp geometry and counters
  always_comb begin
    if (cfg_i.row_width < RW_REG_W'(2)) begin
      last_col_w = CW'(1);
    end else if (32'(cfg_i.row_width) > 32'(MAX_WIDTH)) begin
      last_col_w = CW'(MAX_WIDTH - 1);
    end else begin
      last_col_w = CW'(cfg_i.row_width - RW_REG_W'(1));
    end
    last_row_w = (cfg_i.row_count < RC_REG_W'(2)) ? ROW_W'(1) : cfg_i.row_count - ROW_W'(1);
    c_cur = (col_q > last_col_w) ? last_col_w : col_q;
    r_cur = (row_q > last_row_w) ? last_row_w : row_q;
  end

  assign in_i.ready = (state_q == ST_IDLE);
  assign accept     = in_i.valid && in_i.ready;

  // Read column c, c+1, c-1 and c-2 in turn
  always_comb begin
    unique case (rd_cnt_q[1:0])
      2'd0:    rd_addr = c_q;
      2'd1:    rd_addr = c_q + CW'(1);
      2'd2:    rd_addr = c_q - CW'(1);
      default: rd_addr = c_q - CW'(2);
    endcase
  end

  // Build the jobs of this item
  height_t mid, up, left, right, ctr, lft1, nmin, nmax;
  job_t    j0, j1, j2;
  logic    v0, v1, v2;

  always_comb begin
    mid   = slot_q[0][HEIGHT_BITS-1:0];
    up    = (r_q == ROW_W'(1)) ? mid : slot_q[0][WW-1:HEIGHT_BITS];
    left  = (c_q == '0) ? mid : left_q;
    right = lastcol_q ? mid : slot_q[1][HEIGHT_BITS-1:0];
    ctr   = slot_q[2][HEIGHT_BITS-1:0];
    lft1  = (c_q == CW'(1)) ? ctr : slot_q[3][HEIGHT_BITS-1:0];
    nmin  = (h_q < min_q) ? h_q : min_q;
    nmax  = (h_q > max_q) ? h_q : max_q;

    v0 = (r_q != '0);
    v1 = v0 && lastrow_q && (c_q != '0);
    v2 = v0 && lastrow_q && lastcol_q;

    j0.dx    = diff(right, left);
    j0.dy    = diff(h_q, up);
    j0.xx2   = !((c_q == '0) || lastcol_q);
    j0.yy2   = (r_q != ROW_W'(1));
    j0.col   = COL_W'(c_q);
    j0.row   = r_q - ROW_W'(1);
    j0.last  = !v1 && !v2;
    j0.fdone = 1'b0;
    j0.hmin  = nmin;
    j0.hmax  = nmax;

    j1.dx    = diff(h_q, lft1);
    j1.dy    = diff(ctr, slot_q[2][WW-1:HEIGHT_BITS]);
    j1.xx2   = (c_q != CW'(1));
    j1.yy2   = 1'b0;
    j1.col   = COL_W'(c_q - CW'(1));
    j1.row   = r_q;
    j1.last  = !v2;
    j1.fdone = 1'b0;
    j1.hmin  = nmin;
    j1.hmax  = nmax;

    j2.dx    = diff(h_q, ctr);
    j2.dy    = diff(h_q, mid);
    j2.xx2   = 1'b0;
    j2.yy2   = 1'b0;
    j2.col   = COL_W'(c_q);
    j2.row   = r_q;
    j2.last  = 1'b1;
    j2.fdone = 1'b1;
    j2.hmin  = nmin;
    j2.hmax  = nmax;

    wdata  = v0 ? {mid, h_q} : {slot_q[0][WW-1:HEIGHT_BITS], h_q};
    mem_we = (state_q == ST_CALC);
  end

  assign job_o       = jobs_q[push_idx_q];
  assign job_valid_o = (state_q == ST_PUSH) && jv_q[push_idx_q];

  // Sequence one item: accept, read, compute, and push when there are jobs
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (accept) state_d = ST_READ;
      ST_READ: if (rd_cnt_q == 3'd4) state_d = ST_CALC;
      ST_CALC: state_d = v0 ? ST_PUSH : ST_IDLE;
      ST_PUSH: begin
        if ((!jv_q[push_idx_q] || job_ready_i) && push_idx_q == 2'd2) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[c_q] <= wdata;
    rdata_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      h_q       <= in_i.height;
      c_q       <= c_cur;
      r_q       <= r_cur;
      lastcol_q <= (c_cur == last_col_w);
      lastrow_q <= (r_cur == last_row_w);
    end
    if (state_q == ST_READ && rd_cnt_q != 3'd0) slot_q[2'(rd_cnt_q - 3'd1)] <= rdata_q;
    if (state_q == ST_CALC) begin
      jobs_q[0] <= j0;
      jobs_q[1] <= j1;
      jobs_q[2] <= j2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      col_q      <= '0;
      row_q      <= '0;
      left_q     <= '0;
      min_q      <= HEIGHT_MAX;
      max_q      <= HEIGHT_MIN;
      rd_cnt_q   <= '0;
      jv_q       <= '0;
      push_idx_q <= '0;
    end else begin
      state_q <= state_d;
      // Step through the reads
      if (accept) rd_cnt_q <= '0;
      else if (state_q == ST_READ) rd_cnt_q <= rd_cnt_q + 3'd1;
      // Commit counters, extremes and jobs
      if (state_q == ST_CALC) begin
        jv_q       <= {v2, v1, v0};
        push_idx_q <= '0;
        if (v0) left_q <= mid;
        if (lastcol_q) begin
          col_q <= '0;
          if (lastrow_q) begin
            row_q <= '0;
            min_q <= HEIGHT_MAX;
            max_q <= HEIGHT_MIN;
          end else begin
            row_q <= r_q + ROW_W'(1);
            min_q <= nmin;
            max_q <= nmax;
          end
        end else begin
          col_q <= c_q + CW'(1);
          row_q <= r_q;
          min_q <= nmin;
          max_q <= nmax;
        end
      end
      // Advance past jobs that are sent or absent
      if (state_q == ST_PUSH && (!jv_q[push_idx_q] || job_ready_i) && push_idx_q != 2'd2) begin
        push_idx_q <= push_idx_q + 2'd1;
      end
    end
  end

endmodule

@@ design/hns_queue.sv @@
// Job queue between the front end and the normalizer.
module hns_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  hns_pkg::job_t push_data_i,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  output hns_pkg::job_t pop_data_o,
  output logic          pop_valid_o,
  input  logic          pop_ready_i
);
  import hns_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);

  job_t          entry_q [QUEUE_DEPTH];
  logic [PW-1:0] wr_q, rd_q;
  logic [PW:0]   count_q;
  logic          push, pop;

  assign push_ready_o = (count_q != (PW+1)'(QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = entry_q[rd_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) entry_q[wr_q] <= push_data_i;
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + PW'(1);
      if (pop) rd_q <= rd_q + PW'(1);
      if (push && !pop) count_q <= count_q + (PW+1)'(1);
      else if (pop && !push) count_q <= count_q - (PW+1)'(1);
    end
  end

endmodule

@@ design/hns_back.sv @@
// Back end: normalizes one job at a time with a shared root and three dividers.
`include "heightfield_normal_stencil_macros.svh"

module hns_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  hns_pkg::job_t job_i,
  input  logic          job_valid_i,
  output logic          job_ready_o,
  hns_out_if.source     out_o
);
  import hns_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SQ   = 3'd1;
  localparam logic [2:0] ST_ROOT = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  localparam int DCW = $clog2(NUM_W);
  localparam logic [MAG_W-1:0] Z_BASE = MAG_W'(1) << HFRAC;
  localparam logic [NUM_W-1:0] ONE    = NUM_W'(1) << NORMAL_FRAC_BITS;

  logic [2:0]         state_q;
  job_t               job_q;
  logic [MAG_W-1:0]   mag_q [3];
  logic [1:0]         sq_cnt_q;
  logic [SUM_W-1:0]   sum_q, rv_q, rr_q, rbit_q;
  logic [ROOT_W-1:0]  s_q;
  logic [NUM_W-1:0]   num_q [3];
  logic [REM_W-1:0]   rem_q [3];
  logic [DCW-1:0]     div_cnt_q;
  logic               ovalid_q;

  logic [DIFF_W-1:0]  absx, absy;
  logic [2*MAG_W-1:0] prod;
  logic [SUM_W-1:0]   trial, rr_next;
  logic               ge;
  logic [NUM_W-1:0]   qc [3];

  assign job_ready_o = (state_q == ST_IDLE);
  assign out_o.valid = ovalid_q;

  always_comb begin
    absx    = job_i.dx[DIFF_W-1] ? DIFF_W'(-job_i.dx) : DIFF_W'(job_i.dx);
    absy    = job_i.dy[DIFF_W-1] ? DIFF_W'(-job_i.dy) : DIFF_W'(job_i.dy);
    prod    = mag_q[sq_cnt_q] * mag_q[sq_cnt_q];
    trial   = rr_q + rbit_q;
    ge      = (rv_q >= trial);
    rr_next = ge ? ((rr_q >> 1) + rbit_q) : (rr_q >> 1);
    for (int k = 0; k < 3; k++) begin
      qc[k] = (num_q[k] > ONE) ? ONE : num_q[k];
    end
  end

  always_ff @(posedge clk_i) begin
    // Take a job and form magnitudes
    if (state_q == ST_IDLE && job_valid_i) begin
      job_q    <= job_i;
      mag_q[0] <= MAG_W'(absx) << job_i.yy2;
      mag_q[1] <= MAG_W'(absy) << job_i.xx2;
      unique case ({job_i.xx2, job_i.yy2})
        2'b11:   mag_q[2] <= Z_BASE << 2;
        2'b10,
        2'b01:   mag_q[2] <= Z_BASE << 1;
        default: mag_q[2] <= Z_BASE;
      endcase
      sum_q <= '0;
    end
    // Accumulate squares, one a cycle
    if (state_q == ST_SQ) begin
      sum_q <= sum_q + SUM_W'(prod);
      if (sq_cnt_q == 2'd2) begin
        rv_q   <= sum_q + SUM_W'(prod);
        rr_q   <= '0;
        rbit_q <= SUM_W'(1) << (SUM_W - 2);
      end
    end
    // One root digit a cycle
    if (state_q == ST_ROOT) begin
      if (ge) rv_q <= rv_q - trial;
      rr_q   <= rr_next;
      rbit_q <= rbit_q >> 2;
      if (rbit_q[0]) begin
        s_q <= (rr_next == '0) ? ROOT_W'(1) : ROOT_W'(rr_next);
        for (int k = 0; k < 3; k++) begin
          rem_q[k] <= '0;
          num_q[k] <= (NUM_W'(mag_q[k]) << NORMAL_FRAC_BITS)
                      + NUM_W'(((rr_next == '0) ? ROOT_W'(1) : ROOT_W'(rr_next)) >> 1);
        end
      end
    end
    // One quotient bit a cycle on each lane
    if (state_q == ST_DIV) begin
      for (int k = 0; k < 3; k++) begin
        if ({rem_q[k][REM_W-2:0], num_q[k][NUM_W-1]} >= REM_W'(s_q)) begin
          rem_q[k] <= {rem_q[k][REM_W-2:0], num_q[k][NUM_W-1]} - REM_W'(s_q);
          num_q[k] <= {num_q[k][NUM_W-2:0], 1'b1};
        end else begin
          rem_q[k] <= {rem_q[k][REM_W-2:0], num_q[k][NUM_W-1]};
          num_q[k] <= {num_q[k][NUM_W-2:0], 1'b0};
        end
      end
    end
    // Load the output register
    if (state_q == ST_OUT && (!ovalid_q || out_o.ready)) begin
      out_o.normal_x    <= job_q.dx[DIFF_W-1] ? -NXY_W'(qc[0]) : NXY_W'(qc[0]);
      out_o.normal_y    <= job_q.dy[DIFF_W-1] ? -NXY_W'(qc[1]) : NXY_W'(qc[1]);
      out_o.normal_z    <= NZ_W'(qc[2]);
      out_o.col         <= job_q.col;
      out_o.row_index   <= job_q.row;
      out_o.last_of_run <= job_q.last;
      out_o.frame_done  <= job_q.fdone;
      out_o.height_min  <= job_q.hmin;
      out_o.height_max  <= job_q.hmax;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      sq_cnt_q  <= '0;
      div_cnt_q <= '0;
      ovalid_q  <= 1'b0;
    end else begin
      if (ovalid_q && out_o.ready) ovalid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          sq_cnt_q <= '0;
          if (job_valid_i) state_q <= ST_SQ;
        end
        ST_SQ: begin
          sq_cnt_q <= sq_cnt_q + 2'd1;
          if (sq_cnt_q == 2'd2) state_q <= ST_ROOT;
        end
        ST_ROOT: begin
          div_cnt_q <= DCW'(NUM_W - 1);
          if (rbit_q[0]) state_q <= ST_DIV;
        end
        ST_DIV: begin
          div_cnt_q <= div_cnt_q - DCW'(1);
          if (div_cnt_q == '0) state_q <= ST_OUT;
        end
        ST_OUT: begin
          if (!ovalid_q || out_o.ready) begin
            ovalid_q <= 1'b1;
            state_q  <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  `HNS_ASSERT(a_div_nonzero, (state_q == ST_DIV) |-> (s_q != '0))
  `HNS_ASSERT(a_done_is_last, (ovalid_q && out_o.frame_done) |-> out_o.last_of_run)
  `HNS_ASSERT(a_x_unit, ovalid_q |-> ((out_o.normal_x <= 16'sd16384) && (out_o.normal_x >= -16'sd16384)))

endmodule

@@ design/heightfield_normal_stencil.sv @@
// Top level of the heightfield normal stencil: config registers, front end, queue, normalizer.
//
//   channel   dir  handshake          payload
//   in_i      in   valid/ready        height
//   out_o     out  valid/ready        normal_x/y/z, col, row_index, flags, height_min/max
//   apb       in   psel/penable/...   row_width at 0x0, row_count at 0x4
//
// The front end takes one height at a time and no new one until it is done: accept, the
// line-buffer reads and commit, then, when the height yields normals, a push step for each
// job slot; a full queue stretches the pushes. The normalizer takes one normal at a time and
// no new job until its result is loaded: squaring, then the bit-serial root and dividers.
// Reset clears counters, extremes and control; line buffers are not cleared.
// A stalled output holds the normalizer; a full queue holds the front end.
module heightfield_normal_stencil #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  hns_in_if.sink      in_i,
  hns_out_if.source   out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import hns_pkg::*;

  cfg_t cfg_q;
  job_t f_job, q_job;
  logic f_valid, f_ready, q_valid, q_ready;

  assign pready = 1'b1;

  // Return the addressed register
  always_comb begin
    unique case (paddr[2])
      REG_ROW_WIDTH: prdata = 32'(cfg_q.row_width);
      default:       prdata = 32'(cfg_q.row_count);
    endcase
  end

  // Write configuration on the access cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.row_width <= RW_REG_W'(1024);
      cfg_q.row_count <= RC_REG_W'(1024);
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_ROW_WIDTH: cfg_q.row_width <= pwdata[RW_REG_W-1:0];
        default:       cfg_q.row_count <= pwdata[RC_REG_W-1:0];
      endcase
    end
  end

  hns_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cfg_i       (cfg_q),
    .job_o       (f_job),
    .job_valid_o (f_valid),
    .job_ready_i (f_ready)
  );

  hns_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_data_i  (f_job),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .pop_data_o   (q_job),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready)
  );

  hns_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (q_job),
    .job_valid_i (q_valid),
    .job_ready_o (q_ready),
    .out_o       (out_o)
  );

endmodule

@@ tb/tb_heightfield_normal_stencil.sv @@
// Testbench for heightfield_normal_stencil: directed and random height grids checked against a predictor.
`timescale 1ns / 1ps

module tb_heightfield_normal_stencil;
  import hns_pkg::*;

  localparam int WDOG_LIMIT = 20000;
  localparam int DRAIN_GAP  = 400;

  typedef struct packed {
    logic signed [NXY_W-1:0] nx;
    logic signed [NXY_W-1:0] ny;
    logic [NZ_W-1:0]         nz;
    logic [COL_W-1:0]        col;
    logic [ROW_W-1:0]        row;
    logic                    last;
    logic                    fdone;
    height_t                 hmin;
    height_t                 hmax;
  } normal_t;

  // Grid predictor and result scoreboard
  class normal_scoreboard;
    longint  buf_prev[1024];
    longint  buf_cur[1024];
    longint  left_h;
    int      col_cnt;
    int      row_cnt;
    longint  lo_h;
    longint  hi_h;
    int      width_reg;
    int      count_reg;
    normal_t pending[$];
    normal_t step_out[$];
    int      mismatches;
    int      n_checked;
    int      n_heights;

    function new();
      left_h = 0; col_cnt = 0; row_cnt = 0;
      lo_h = 32767; hi_h = -32768;
      width_reg = 1024; count_reg = 1024;
      mismatches = 0; n_checked = 0; n_heights = 0;
    endfunction

    function void set_geometry(int w, int rc);
      width_reg = w;
      count_reg = rc;
    endfunction

    function longint unsigned root(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    function longint unsigned scale(longint unsigned m, longint unsigned s);
      longint unsigned q;
      q = ((m << NORMAL_FRAC_BITS) + s / 2) / s;
      if (q > (64'd1 << NORMAL_FRAC_BITS)) q = 64'd1 << NORMAL_FRAC_BITS;
      return q;
    endfunction

    // Normalize one gradient and queue it for this step
    function void add_normal(longint dx, longint dy, longint xx, longint yy,
                             int c, int r, bit fd);
      longint          vx, vy;
      longint unsigned mx, my, mz, s, qx, qy;
      normal_t         n;
      vx = yy * dx;
      vy = xx * dy;
      mx = vx < 0 ? -vx : vx;
      my = vy < 0 ? -vy : vy;
      mz = (xx * yy) << HFRAC;
      while (mx >= 64'h8000_0000 || my >= 64'h8000_0000 || mz >= 64'h8000_0000) begin
        mx >>= 1; my >>= 1; mz >>= 1;
      end
      s = root(mx * mx + my * my + mz * mz);
      if (s == 0) s = 1;
      qx = scale(mx, s);
      qy = scale(my, s);
      n.nx = vx < 0 ? NXY_W'(-qx) : NXY_W'(qx);
      n.ny = vy < 0 ? NXY_W'(-qy) : NXY_W'(qy);
      n.nz = NZ_W'(scale(mz, s));
      n.col = COL_W'(c);
      n.row = ROW_W'(r);
      n.last = 1'b0;
      n.fdone = fd;
      n.hmin = HEIGHT_BITS'(lo_h);
      n.hmax = HEIGHT_BITS'(hi_h);
      step_out.push_back(n);
    endfunction

    // Advance the grid by one accepted height
    function void note_height(height_t hv);
      longint h, mid, up, lft, rgt, ctr;
      int     w, rc, c, r, q;
      bit     lastcol, lastrow;
      h = longint'(hv);
      n_heights++;
      if (h < lo_h) lo_h = h;
      if (h > hi_h) hi_h = h;
      w = width_reg < 2 ? 2 : (width_reg > 1024 ? 1024 : width_reg);
      rc = count_reg < 2 ? 2 : count_reg;
      c = col_cnt > w - 1 ? w - 1 : col_cnt;
      r = row_cnt > rc - 1 ? rc - 1 : row_cnt;
      lastcol = (c == w - 1);
      lastrow = (r == rc - 1);
      step_out.delete();
      if (r == 0) begin
        buf_cur[c] = h;
      end else begin
        mid = buf_cur[c];
        up = (r == 1) ? mid : buf_prev[c];
        lft = (c == 0) ? mid : left_h;
        rgt = lastcol ? mid : buf_cur[c+1];
        add_normal(rgt - lft, h - up, (c == 0 || lastcol) ? 1 : 2, (r == 1) ? 1 : 2,
                   c, r - 1, 1'b0);
        left_h = mid;
        buf_prev[c] = mid;
        buf_cur[c] = h;
        if (lastrow) begin
          if (c >= 1) begin
            q = c - 1;
            ctr = buf_cur[q];
            lft = (q == 0) ? ctr : buf_cur[q-1];
            add_normal(h - lft, ctr - buf_prev[q], (q == 0) ? 1 : 2, 1, q, r, 1'b0);
          end
          if (lastcol) begin
            lft = (c == 0) ? h : buf_cur[c-1];
            add_normal(h - lft, h - buf_prev[c], 1, 1, c, r, 1'b1);
          end
        end
      end
      if (step_out.size() > 0) step_out[step_out.size()-1].last = 1'b1;
      foreach (step_out[i]) pending.push_back(step_out[i]);
      // Wrap counters; reset extremes at end of frame
      if (lastcol) begin
        col_cnt = 0;
        if (lastrow) begin
          row_cnt = 0;
          lo_h = 32767;
          hi_h = -32768;
        end else begin
          row_cnt = r + 1;
        end
      end else begin
        col_cnt = c + 1;
        row_cnt = r;
      end
    endfunction

    // Compare one output transaction with the oldest expected normal
    function void check_normal(normal_t got);
      normal_t e;
      n_checked++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected normal col %0d row %0d", got.col, got.row);
        return;
      end
      e = pending.pop_front();
      if (got !== e) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("normal mismatch: exp x %0d y %0d z %0d c %0d r %0d l %0b f %0b mn %0d mx %0d",
                   e.nx, e.ny, e.nz, e.col, e.row, e.last, e.fdone, e.hmin, e.hmax);
          $display("                 got x %0d y %0d z %0d c %0d r %0d l %0b f %0b mn %0d mx %0d",
                   got.nx, got.ny, got.nz, got.col, got.row, got.last, got.fdone,
                   got.hmin, got.hmax);
        end
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int          tx_idle;
  int          rx_idle;
  int          quiet_cycles;
  height_t     ramp_h;

  normal_scoreboard sb;

  hns_in_if  in_ch ();
  hns_out_if out_ch ();

  heightfield_normal_stencil u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_ch.sink),
    .out_o   (out_ch.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Randomly stall the output side
  always @(posedge clk_i) begin
    out_ch.ready <= ($urandom_range(99) >= rx_idle);
  end

  // Monitor both channels and run the watchdog
  always @(posedge clk_i) begin
    normal_t got;
    bit      moved;
    moved = 1'b0;
    if (rst_ni) begin
      if (in_ch.valid && in_ch.ready) begin
        sb.note_height(in_ch.height);
        moved = 1'b1;
      end
      if (out_ch.valid && out_ch.ready) begin
        got.nx = out_ch.normal_x;
        got.ny = out_ch.normal_y;
        got.nz = out_ch.normal_z;
        got.col = out_ch.col;
        got.row = out_ch.row_index;
        got.last = out_ch.last_of_run;
        got.fdone = out_ch.frame_done;
        got.hmin = out_ch.height_min;
        got.hmax = out_ch.height_max;
        sb.check_normal(got);
        moved = 1'b1;
      end
      quiet_cycles <= moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles > WDOG_LIMIT) begin
        $display("[heightfield_normal_stencil] ERROR");
        $finish;
      end
    end
  end

  // APB write: setup then access cycle
  task automatic reg_write(logic idx, int value);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_geometry(int w, int rc);
    reg_write(REG_ROW_WIDTH, w);
    reg_write(REG_ROW_COUNT, rc);
    sb.set_geometry(w, rc);
  endtask

  // Send one height, with an occasional gap before it
  task automatic send_height(height_t h);
    if ($urandom_range(99) < tx_idle) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.height <= h;
    do @(posedge clk_i); while (!(in_ch.valid && in_ch.ready));
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_GAP) @(posedge clk_i);
  endtask

  // Random frame: mostly smooth terrain with some full-range heights
  task automatic random_frame(int w, int rc);
    set_geometry(w, rc);
    ramp_h = HEIGHT_BITS'($urandom);
    for (int i = 0; i < (w < 2 ? 2 : w) * (rc < 2 ? 2 : rc); i++) begin
      if ($urandom_range(3) == 0) ramp_h = HEIGHT_BITS'($urandom);
      else ramp_h = HEIGHT_BITS'(int'(ramp_h) + int'($urandom_range(1024)) - 512);
      send_height(ramp_h);
    end
    drain();
  endtask

  initial begin
    sb = new();
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.height = '0;
    out_ch.ready = 1'b0;
    quiet_cycles = 0;
    tx_idle = 10;
    rx_idle = 86;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed 3x3 frame: extremes, edges, interior, last row and last vertex
    set_geometry(3, 3);
    send_height(HEIGHT_MAX); send_height(HEIGHT_MIN); send_height('0);
    send_height(HEIGHT_MIN); send_height(HEIGHT_MAX); send_height('0);
    send_height(16'sd256);   send_height(-16'sd256);  send_height(16'sd1);
    drain();
    // Out-of-range geometry clamps to 2x2
    set_geometry(0, 1);
    send_height(HEIGHT_MAX); send_height(HEIGHT_MAX);
    send_height(HEIGHT_MIN); send_height(-16'sd1);
    drain();
    random_frame(5, 3);
    random_frame(2, 6);

    tx_idle = 86;
    rx_idle = 10;
    random_frame(7, 3);
    random_frame(4, 4);

    tx_idle = 0;
    rx_idle = 0;
    random_frame(6, 3);
    random_frame(8, 2);

    $display("covered %0d heights and %0d normals over frames from 2x2 up to 8 wide",
             sb.n_heights, sb.n_checked);
    $display("with output stalls, input gaps, clamped geometry and extreme heights");
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("[heightfield_normal_stencil] OK");
    end else begin
      $display("[heightfield_normal_stencil] ERROR");
    end
    $finish;
  end

endmodule
